FILE: rtl/gns_pkg.sv
package gns_pkg;

  // fixed widths of the item fields and state
  localparam int SAMPLE_W   = 16;
  localparam int MAX_GROUP  = 4096;
  localparam int CNT_W      = 13;
  localparam int SUM_W      = 29;
  localparam int SQ_W       = 43;
  localparam int INV_W      = 32;
  localparam int DVD_W      = 56;
  localparam int DVS_W      = 32;
  localparam int DIV_STEPS  = 56;
  localparam int SQRT_STEPS = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWISH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AFFINE  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] sample;
    logic [15:0] gamma;
    logic [15:0] beta;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_F0, ST_F1, ST_F2, ST_F3, ST_WMEAN, ST_WVAR, ST_DCHK,
    ST_WRCP, ST_SQRT, ST_INV, ST_N2, ST_N3, ST_N4, ST_N5, ST_N6
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ACC, OP_F0, OP_F1, OP_F2, OP_F3, OP_MEAN, OP_VAR,
    OP_RCP, OP_SQRT_LOAD, OP_SQRT_STEP, OP_INV_SAVE, OP_INV_MAX,
    OP_N1, OP_N2, OP_N3, OP_N4, OP_N5, OP_N6
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_norm;
    logic is_last;
    logic div_done;
    logic var_zero;
    logic sqrt_last;
  } dp_status_t;

  // sigmoid over [0,8] in quarter steps, Q0.16
  localparam logic [15:0] SIG_TAB [33] = '{
    16'd32768, 16'd36843, 16'd40793, 16'd44510, 16'd47910, 16'd50941, 16'd53580,
    16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61597, 16'd62428, 16'd63090,
    16'd63615, 16'd64030, 16'd64357, 16'd64614, 16'd64816, 16'd64974, 16'd65097,
    16'd65194, 16'd65269, 16'd65328, 16'd65374, 16'd65410, 16'd65438, 16'd65459,
    16'd65476, 16'd65490, 16'd65500, 16'd65508, 16'd65514
  };

endpackage

FILE: rtl/gns_div.sv
module gns_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gns_pkg::DVD_W-1:0] dividend,
  input  logic [gns_pkg::DVS_W-1:0] divisor,
  output logic [gns_pkg::DVD_W-1:0] quotient,
  output logic                      done
);

  localparam int CW = $clog2(gns_pkg::DIV_STEPS);

  logic                      busy_r;
  logic                      done_r;
  logic [CW-1:0]             cnt_r;
  logic [gns_pkg::DVD_W-1:0] q_r;
  logic [gns_pkg::DVS_W-1:0] rem_r;
  logic [gns_pkg::DVS_W-1:0] dvs_r;
  logic [gns_pkg::DVS_W:0]   rem_t;
  logic [gns_pkg::DVS_W:0]   rem_d;
  logic                      ge;

  // one restoring step a cycle
  always_comb begin
    rem_t = {rem_r, q_r[gns_pkg::DVD_W-1]};
    ge    = rem_t >= {1'b0, dvs_r};
    rem_d = ge ? rem_t - {1'b0, dvs_r} : rem_t;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(gns_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[gns_pkg::DVD_W-2:0], ge};
      rem_r <= rem_d[gns_pkg::DVS_W-1:0];
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while running");
  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (rem_r < dvs_r)) else $error("remainder not below divisor");

endmodule

FILE: rtl/gns_ctrl.sv
module gns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gns_pkg::dp_status_t status,
  output gns_pkg::dp_cmd_t    cmd
);

  gns_pkg::state_t state_r;
  gns_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gns_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of accumulate, group finish and normalize steps
  always_comb begin
    state_nxt = state_r;
    cmd.op    = gns_pkg::OP_NONE;
    unique case (state_r)
      gns_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op    = gns_pkg::OP_LOAD;
          state_nxt = gns_pkg::ST_EXEC;
        end
      end
      gns_pkg::ST_EXEC: begin
        if (status.is_norm) begin
          cmd.op    = gns_pkg::OP_N1;
          state_nxt = gns_pkg::ST_N2;
        end else begin
          cmd.op    = gns_pkg::OP_ACC;
          state_nxt = status.is_last ? gns_pkg::ST_F0 : gns_pkg::ST_IDLE;
        end
      end
      gns_pkg::ST_F0: begin
        cmd.op    = gns_pkg::OP_F0;
        state_nxt = gns_pkg::ST_F1;
      end
      gns_pkg::ST_F1: begin
        cmd.op    = gns_pkg::OP_F1;
        state_nxt = gns_pkg::ST_F2;
      end
      gns_pkg::ST_F2: begin
        cmd.op    = gns_pkg::OP_F2;
        state_nxt = gns_pkg::ST_F3;
      end
      gns_pkg::ST_F3: begin
        cmd.op    = gns_pkg::OP_F3;
        state_nxt = gns_pkg::ST_WMEAN;
      end
      gns_pkg::ST_WMEAN: begin
        if (status.div_done) begin
          cmd.op    = gns_pkg::OP_MEAN;
          state_nxt = gns_pkg::ST_WVAR;
        end
      end
      gns_pkg::ST_WVAR: begin
        if (status.div_done) begin
          cmd.op    = gns_pkg::OP_VAR;
          state_nxt = gns_pkg::ST_DCHK;
        end
      end
      gns_pkg::ST_DCHK: begin
        if (status.var_zero) begin
          cmd.op    = gns_pkg::OP_INV_MAX;
          state_nxt = gns_pkg::ST_IDLE;
        end else begin
          cmd.op    = gns_pkg::OP_RCP;
          state_nxt = gns_pkg::ST_WRCP;
        end
      end
      gns_pkg::ST_WRCP: begin
        if (status.div_done) begin
          cmd.op    = gns_pkg::OP_SQRT_LOAD;
          state_nxt = gns_pkg::ST_SQRT;
        end
      end
      gns_pkg::ST_SQRT: begin
        cmd.op = gns_pkg::OP_SQRT_STEP;
        if (status.sqrt_last) begin
          state_nxt = gns_pkg::ST_INV;
        end
      end
      gns_pkg::ST_INV: begin
        cmd.op    = gns_pkg::OP_INV_SAVE;
        state_nxt = gns_pkg::ST_IDLE;
      end
      gns_pkg::ST_N2: begin
        cmd.op    = gns_pkg::OP_N2;
        state_nxt = gns_pkg::ST_N3;
      end
      gns_pkg::ST_N3: begin
        cmd.op    = gns_pkg::OP_N3;
        state_nxt = gns_pkg::ST_N4;
      end
      gns_pkg::ST_N4: begin
        cmd.op    = gns_pkg::OP_N4;
        state_nxt = gns_pkg::ST_N5;
      end
      gns_pkg::ST_N5: begin
        cmd.op    = gns_pkg::OP_N5;
        state_nxt = gns_pkg::ST_N6;
      end
      gns_pkg::ST_N6: begin
        cmd.op    = gns_pkg::OP_N6;
        state_nxt = gns_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gns_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = state_r != gns_pkg::ST_IDLE;

endmodule

FILE: rtl/gns_dp.sv
module gns_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gns_pkg::in_item_t             in_item,
  input  logic                          cfg_we,
  input  logic [gns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gns_pkg::CFG_DATA_W-1:0] cfg_data,
  input  gns_pkg::dp_cmd_t              cmd,
  output gns_pkg::dp_status_t           status,
  output logic                          out_strobe,
  output gns_pkg::out_item_t            out_item
);

  localparam int SCW = $clog2(gns_pkg::SQRT_STEPS);

  // configuration
  logic [15:0] eps_r;
  logic        swish_r;
  logic        affine_r;

  // item and group state
  gns_pkg::in_item_t                item_r;
  logic signed [gns_pkg::SUM_W-1:0] sum_r;
  logic [gns_pkg::SQ_W-1:0]         sq_r;
  logic [gns_pkg::CNT_W-1:0]        cnt_r;
  logic [15:0]                      mean_r;
  logic [gns_pkg::INV_W-1:0]        inv_r;

  // finish datapath
  logic [34:0] mlo_r;
  logic [33:0] mhi_r;
  logic [25:0] nn_r;
  logic [57:0] sqs_r;
  logic [55:0] num_r;
  logic [31:0] d_r;
  logic [48:0] sn_r;
  logic [48:0] sr_r;
  logic [48:0] sb_r;
  logic [SCW-1:0] scnt_r;

  // normalize datapath
  logic signed [49:0] p1_r;
  logic signed [41:0] ra_r;
  logic signed [57:0] pg_r;
  logic signed [45:0] r16_r;
  logic [16:0]        s_r;
  logic signed [63:0] pw_r;
  logic               out_strobe_r;
  gns_pkg::out_item_t out_item_r;

  // divider hookup
  logic                      div_start;
  logic [gns_pkg::DVD_W-1:0] div_dvd;
  logic [gns_pkg::DVS_W-1:0] div_dvs;
  logic [gns_pkg::DVD_W-1:0] div_q;
  logic                      div_done;

  // combinational helpers
  logic signed [16:0] xe;
  logic [16:0]        ax;
  logic [33:0]        ax2;
  logic               cnt_full;
  logic [28:0]        asum;
  logic signed [29:0] soff;
  logic [57:0]        nq;
  logic [49:0]        trial;
  logic signed [16:0] cen;
  logic signed [49:0] p1_rnd;
  logic signed [41:0] r16a;
  logic signed [57:0] aff;
  logic [45:0]        mag;
  logic               big;
  logic [4:0]         ti;
  logic [15:0]        tlo;
  logic [15:0]        thi;
  logic [29:0]        ip;
  logic [16:0]        spos;
  logic signed [63:0] pw_rnd;
  logic signed [45:0] r16_rnd;
  logic signed [39:0] vv;

  gns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r    <= 16'd1;
      swish_r  <= 1'b0;
      affine_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gns_pkg::CFG_EPSILON: eps_r    <= cfg_data;
        gns_pkg::CFG_SWISH:   swish_r  <= cfg_data[0];
        gns_pkg::CFG_AFFINE:  affine_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // accumulate and finish helpers
  always_comb begin
    xe       = 17'($signed(item_r.sample));
    ax       = xe[16] ? 17'(-xe) : 17'(xe);
    ax2      = 34'(ax) * 34'(ax);
    cnt_full = cnt_r == gns_pkg::CNT_W'(gns_pkg::MAX_GROUP);
    asum     = sum_r[gns_pkg::SUM_W-1] ? 29'(-sum_r) : 29'(sum_r);
    soff     = 30'(sum_r) + $signed({2'b00, cnt_r, 15'd0});
    nq       = {2'b00, mhi_r, 22'd0} + 58'(mlo_r);
    trial    = 50'(sr_r) + 50'(sb_r);
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 32'd1;
    case (cmd.op)
      gns_pkg::OP_F3: begin
        div_start = 1'b1;
        div_dvd   = 56'({soff[28:0], 1'b0}) + 56'(cnt_r);
        div_dvs   = 32'({cnt_r, 1'b0});
      end
      gns_pkg::OP_MEAN: begin
        div_start = 1'b1;
        div_dvd   = num_r;
        div_dvs   = 32'(nn_r);
      end
      gns_pkg::OP_RCP: begin
        div_start = 1'b1;
        div_dvd   = 56'(1) << 48;
        div_dvs   = d_r;
      end
      default: ;
    endcase
  end

  // normalize helpers
  always_comb begin
    cen     = xe - 17'($signed(mean_r));
    p1_rnd  = p1_r + 50'sd128;
    r16a    = p1_rnd[49:8];
    aff     = pg_r + (58'($signed(item_r.beta)) <<< 20) + 58'sd2048;
    mag     = r16_r[45] ? 46'(-r16_r) : 46'(r16_r);
    big     = |mag[45:19];
    ti      = mag[18:14];
    tlo     = gns_pkg::SIG_TAB[ti];
    thi     = gns_pkg::SIG_TAB[6'(ti) + 6'd1];
    ip      = 30'(thi - tlo) * 30'(mag[13:0]);
    spos    = big ? 17'(gns_pkg::SIG_TAB[32]) : 17'(tlo) + 17'(ip[29:14]);
    pw_rnd  = pw_r + 64'sd8388608;
    r16_rnd = r16_r + 46'sd128;
    vv      = swish_r ? pw_rnd[63:24] : 40'($signed(r16_rnd[45:8]));
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sq_r   <= '0;
      cnt_r  <= '0;
      mean_r <= '0;
      inv_r  <= '0;
    end else begin
      case (cmd.op)
        gns_pkg::OP_ACC: begin
          if (!cnt_full) begin
            sum_r <= sum_r + gns_pkg::SUM_W'(xe);
            sq_r  <= sq_r + gns_pkg::SQ_W'(ax2);
            cnt_r <= cnt_r + gns_pkg::CNT_W'(1);
          end
        end
        gns_pkg::OP_MEAN: mean_r <= div_q[15:0] ^ 16'h8000;
        gns_pkg::OP_INV_SAVE: begin
          inv_r <= sr_r[31:0];
          sum_r <= '0;
          sq_r  <= '0;
          cnt_r <= '0;
        end
        gns_pkg::OP_INV_MAX: begin
          inv_r <= '1;
          sum_r <= '0;
          sq_r  <= '0;
          cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers of finish and normalize
  always_ff @(posedge clk) begin
    case (cmd.op)
      gns_pkg::OP_LOAD: item_r <= in_item;
      gns_pkg::OP_F0: begin
        mlo_r <= 35'(cnt_r) * 35'(sq_r[21:0]);
        nn_r  <= 26'(cnt_r) * 26'(cnt_r);
      end
      gns_pkg::OP_F1: mhi_r <= 34'(cnt_r) * 34'(sq_r[42:22]);
      gns_pkg::OP_F2: sqs_r <= 58'(asum) * 58'(asum);
      gns_pkg::OP_F3: begin
        num_r <= 56'(nq - sqs_r);
      end
      gns_pkg::OP_VAR: d_r <= div_q[31:0] + 32'(eps_r);
      gns_pkg::OP_SQRT_LOAD: begin
        sn_r   <= div_q[48:0];
        sr_r   <= '0;
        sb_r   <= 49'(1) << 48;
        scnt_r <= '0;
      end
      gns_pkg::OP_SQRT_STEP: begin
        if (50'(sn_r) >= trial) begin
          sn_r <= sn_r - trial[48:0];
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r   <= sb_r >> 2;
        scnt_r <= scnt_r + SCW'(1);
      end
      gns_pkg::OP_N1: p1_r <= cen * $signed({1'b0, inv_r});
      gns_pkg::OP_N2: begin
        ra_r <= r16a;
        pg_r <= 58'(r16a) * 58'($signed(item_r.gamma));
      end
      gns_pkg::OP_N3: r16_r <= affine_r ? aff[57:12] : 46'(ra_r);
      gns_pkg::OP_N4: s_r <= r16_r[45] ? 17'd65536 - spos : spos;
      gns_pkg::OP_N5: pw_r <= 64'(r16_r) * 64'($signed({1'b0, s_r}));
      gns_pkg::OP_N6: begin
        if (vv > 40'sd32767) begin
          out_item_r.value     <= 16'h7FFF;
          out_item_r.saturated <= 1'b1;
        end else if (vv < -40'sd32768) begin
          out_item_r.value     <= 16'h8000;
          out_item_r.saturated <= 1'b1;
        end else begin
          out_item_r.value     <= vv[15:0];
          out_item_r.saturated <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.op == gns_pkg::OP_N6;
    end
  end

  always_comb begin
    status.is_norm   = item_r.command;
    status.is_last   = item_r.last;
    status.div_done  = div_done;
    status.var_zero  = d_r == '0;
    status.sqrt_last = scnt_r == SCW'(gns_pkg::SQRT_STEPS - 1);
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(cmd.op == gns_pkg::OP_N6)) else $error("stray result strobe");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= gns_pkg::CNT_W'(gns_pkg::MAX_GROUP)) else $error("group count overflow");
  a_inv_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == gns_pkg::OP_INV_SAVE |-> $past(cmd.op == gns_pkg::OP_SQRT_STEP))
    else $error("deviation saved before root finished");

endmodule

FILE: rtl/group_normalization_swish.sv
// channel  | ports                              | direction
// ---------+------------------------------------+----------
// input    | start, busy, in_item               | in, busy out
// result   | out_strobe, out_item               | out
// config   | cfg_we, cfg_index, cfg_data        | in
//
// an item is taken when start is high and busy low; one item at a time.
// accumulate item; the last one also runs the group finish: two 56-step serial
// divisions, then, unless variance plus epsilon is zero, a third and a 25-step root.
// normalize item: steps N1 to N6 of a multiply chain, then a registered result strobe.
// synchronous active-low reset; results are strobed for one cycle and never stall.
module group_normalization_swish (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  gns_pkg::in_item_t              in_item,
  output logic                           out_strobe,
  output gns_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [gns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gns_pkg::CFG_DATA_W-1:0] cfg_data
);

  gns_pkg::dp_cmd_t    cmd;
  gns_pkg::dp_status_t status;

  // sequencer
  gns_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // arithmetic
  gns_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: bench/gns_checker.sv
`timescale 1ns / 1ps

// watches the item and result channels, predicts each result and compares
module gns_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  gns_pkg::in_item_t              in_item,
  input  logic                           out_strobe,
  input  gns_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [gns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gns_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             results_seen
);
  import gns_pkg::*;

  // mirrored configuration
  logic [15:0] eps_q;
  logic        swish_q;
  logic        affine_q;

  // mirrored group statistics
  longint          sum_q;
  longint unsigned sq_q;
  int unsigned     count_q;
  longint          mean_q;
  logic [31:0]     inv_dev_q;

  out_item_t expected_results[$];

  function automatic longint floor_divide(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // nearest, ties toward plus infinity
  function automatic longint round_down_bits(longint v, int k);
    longint one;
    one = 1;
    return (v + (one <<< (k - 1))) >>> k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // x times interpolated sigmoid, Q.32
  function automatic longint silu_q32(longint x);
    longint unsigned a, idx;
    longint s, lo, hi;
    a = (x < 0) ? longint'(-x) : longint'(x);
    idx = a >> 14;
    if (idx >= 32) begin
      s = longint'(SIG_TAB[32]);
    end else begin
      lo = longint'(SIG_TAB[idx]);
      hi = longint'(SIG_TAB[idx + 1]);
      s = lo + (((hi - lo) * longint'(a & 64'h3FFF)) >>> 14);
    end
    if (x < 0) s = 65536 - s;
    return x * s;
  endfunction

  function automatic out_item_t predict_norm(in_item_t it);
    longint x, g, b, r16, v;
    out_item_t res;
    x = longint'($signed(it.sample));
    g = longint'($signed(it.gamma));
    b = longint'($signed(it.beta));
    r16 = round_down_bits((x - mean_q) * longint'({32'b0, inv_dev_q}), 8);
    if (affine_q) r16 = round_down_bits(r16 * g + (b <<< 20), 12);
    if (swish_q) v = round_down_bits(silu_q32(r16), 24);
    else v = round_down_bits(r16, 8);
    res.saturated = 1'b0;
    if (v > 32767) begin
      v = 32767;
      res.saturated = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      res.saturated = 1'b1;
    end
    res.value = v[15:0];
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    longint x, cnt;
    longint unsigned ax, asum, num, var_q, d;
    out_item_t exp_item;
    if (!rst_n) begin
      eps_q <= 16'd1;
      swish_q <= 1'b0;
      affine_q <= 1'b1;
      sum_q <= 0;
      sq_q <= 0;
      count_q <= 0;
      mean_q <= 0;
      inv_dev_q <= '0;
      errors <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_EPSILON: eps_q <= cfg_data;
          CFG_SWISH: swish_q <= cfg_data[0];
          CFG_AFFINE: affine_q <= cfg_data[0];
          default: ;
        endcase
      end
      // accepted item
      if (start && !busy) begin
        if (in_item.command) begin
          expected_results.push_back(predict_norm(in_item));
        end else begin
          x = longint'($signed(in_item.sample));
          ax = (x < 0) ? longint'(-x) : longint'(x);
          if (in_item.last) begin
            if (count_q < MAX_GROUP) begin
              sum_q = sum_q + x;
              sq_q = sq_q + ax * ax;
              count_q = count_q + 1;
            end
            if (count_q != 0) begin
              cnt = longint'(count_q);
              mean_q <= floor_divide(2 * sum_q + cnt, 2 * cnt);
              asum = (sum_q < 0) ? longint'(-sum_q) : longint'(sum_q);
              num = longint'(count_q) * sq_q - asum * asum;
              var_q = num / (longint'(count_q) * longint'(count_q));
              d = var_q + longint'(eps_q);
              if (d == 0) inv_dev_q <= 32'hFFFF_FFFF;
              else inv_dev_q <= int_sqrt((64'd1 << 48) / d);
            end
            sum_q <= 0;
            sq_q <= 0;
            count_q <= 0;
          end else if (count_q < MAX_GROUP) begin
            sum_q <= sum_q + x;
            sq_q <= sq_q + ax * ax;
            count_q <= count_q + 1;
          end
        end
      end
      // result compare
      if (out_strobe) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result value %0d", $signed(out_item.value));
          errors <= errors + 1;
        end else begin
          exp_item = expected_results.pop_front();
          if (exp_item.value !== out_item.value) begin
            $error("value: expected %0d actual %0d", $signed(exp_item.value),
                   $signed(out_item.value));
            errors <= errors + 1;
          end else if (exp_item.saturated !== out_item.saturated) begin
            $error("saturated: expected %0d actual %0d", exp_item.saturated,
                   out_item.saturated);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/tb_group_normalization_swish.sv
`timescale 1ns / 1ps

module tb_group_normalization_swish;
  import gns_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    results_seen;
  int                    items_sent;
  int                    idle_pct;
  int                    phase_items;

  group_normalization_swish u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gns_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
    .pending(pending), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_item_t make_item(logic cmd, logic [15:0] s, logic [15:0] g,
                                         logic [15:0] b, logic l);
    in_item_t it;
    it.command = cmd;
    it.sample = s;
    it.gamma = g;
    it.beta = b;
    it.last = l;
    return it;
  endfunction

  // present one item, optionally after a gap, and hold until taken
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    phase_items++;
  endtask

  // drain results, then let a group finish run out
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [15:0] eps, logic sw, logic af);
    wait_quiet();
    write_reg(CFG_EPSILON, eps);
    write_reg(CFG_SWISH, {15'd0, sw});
    write_reg(CFG_AFFINE, {15'd0, af});
  endtask

  function automatic logic [15:0] near_value(logic [15:0] base, int k);
    return base + 16'($signed($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1)));
  endfunction

  // one group and its normalize pass, or noise
  task automatic random_sequence();
    logic [15:0] base;
    logic [15:0] g;
    logic [15:0] b;
    int n, m, k;
    base = 16'($urandom);
    k = $urandom_range(1, 16);
    if ($urandom_range(99) < 80) begin
      n = ($urandom_range(99) < 5) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_item(make_item(1'b0, near_value(base, k), 16'($urandom), 16'($urandom),
                            i == n - 1));
      m = $urandom_range(1, 8);
      for (int i = 0; i < m; i++) begin
        g = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        b = ($urandom_range(1)) ? 16'($urandom) : near_value(16'd0, 10);
        send_item(make_item(1'b1, near_value(base, k), g, b, 1'($urandom)));
      end
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_item(make_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            1'($urandom)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    idle_pct = 0;
    phase_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // normalize before any group, reset mean and deviation
    send_item(make_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
    send_item(make_item(1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    // group with extreme samples
    send_item(make_item(1'b0, 16'h7FFF, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(make_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, 16'h0100, 16'h0000, 16'h0000, 1'b1));
    send_item(make_item(1'b1, 16'h7FFF, 16'h1000, 16'h0000, 1'b1));
    send_item(make_item(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 1'b0));
    send_item(make_item(1'b1, 16'h0000, 16'h8000, 16'h7FFF, 1'b0));
    send_item(make_item(1'b1, 16'h0040, 16'h1000, 16'h0100, 1'b0));
    // zero deviation: constant group with no stabilizer
    apply_setting(16'd0, 1'b0, 1'b0);
    send_item(make_item(1'b0, 16'h0500, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, 16'h0500, 16'h0000, 16'h0000, 1'b1));
    send_item(make_item(1'b1, 16'h0500, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, 16'h0501, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, 16'h04FF, 16'h0000, 16'h0000, 1'b0));
    // swish with small and large inputs
    apply_setting(16'hFFFF, 1'b1, 1'b1);
    send_item(make_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(1'b0, 16'h0200, 16'h0000, 16'h0000, 1'b1));
    send_item(make_item(1'b1, 16'h0100, 16'h1000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, 16'h0180, 16'h1000, 16'h0000, 1'b0));
    send_item(make_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0));
    send_item(make_item(1'b1, 16'h8000, 16'h7FFF, 16'h0000, 1'b0));
    send_item(make_item(1'b1, 16'h0100, 16'h1000, 16'hF000, 1'b0));

    // random part over three idling phases and several settings
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 6; s++) begin
        case (s)
          0: apply_setting(16'd1, 1'b0, 1'b1);
          1: apply_setting(16'd0, 1'b0, 1'b0);
          2: apply_setting(16'hFFFF, 1'b1, 1'b1);
          3: apply_setting(16'd0, 1'b1, 1'b0);
          4: apply_setting(16'($urandom), 1'b1, 1'b1);
          default: apply_setting(16'($urandom), 1'b0, 1'b1);
        endcase
        idle_pct = (p == 0) ? 37 : ((p == 1) ? 62 : 0);
        phase_items = 0;
        while (phase_items < 80) random_sequence();
      end
    end

    wait_quiet();
    $display("covered %0d items, %0d results, three idling phases, six register settings",
             items_sent, results_seen);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
